// File: design/masked_byte_pattern_scanner_unit_macros.svh
// Assertion helpers; expect clk and rst in the enclosing scope.
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// cond holds -> prop holds in the same cycle
`define MBPS_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: assertion failed");

// cond holds -> prop holds in the following cycle
`define MBPS_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

// File: design/mbps_pkg.sv
package mbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 6;
  localparam int PLEN_W     = 7;
  localparam int HITS_W     = 10;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT   = 2'd1;

  localparam logic [PLEN_W-1:0] PATTERN_LEN_RESET = 7'd1;
  localparam logic [HITS_W-1:0] HIT_LIMIT_RESET   = 10'd1000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  pattern_index;
    logic [BYTE_W-1:0] pattern_byte;
    logic              care;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic              match_here;
    logic [POS_W-1:0]  match_start;
    logic [HITS_W-1:0] hit_count;
    logic              first_found;
    logic [POS_W-1:0]  first_offset;
    logic              section_done;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic out_free;
  } status_t;

endpackage

// File: design/mbps_ctrl.sv
`include "masked_byte_pattern_scanner_unit_macros.svh"

module mbps_ctrl
  import mbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, EMIT} state_t;

  state_t state;

  always_comb begin
    cmd.accept = in_valid && in_ready;
    cmd.issue  = (state == SCAN);
    cmd.load   = (state == EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.accept) begin
            in_ready <= 1'b0;
            state    <= (in_op == OP_SCAN) ? SCAN : EMIT;
          end
        end
        SCAN: begin
          if (status.k_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= EMIT;
        end
        EMIT: begin
          if (status.out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `MBPS_ASSERT_NXT(a_scan_entered, in_valid && in_ready && in_op == OP_SCAN, state == SCAN)
  `MBPS_ASSERT_NXT(a_write_to_emit, in_valid && in_ready && in_op == OP_WRITE, state == EMIT)
  `MBPS_ASSERT_IMP(a_ready_when_idle, in_ready, state == IDLE)

endmodule

// File: design/mbps_datapath.sv
`include "masked_byte_pattern_scanner_unit_macros.svh"

module mbps_datapath
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_item,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int WD = 1 << AW;

  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

  pat_entry_t        pat_mem [PATTERN_MAX];
  logic [BYTE_W-1:0] win_mem [WD];

  logic [PLEN_W-1:0] pattern_len;
  logic [HITS_W-1:0] hit_limit;

  logic [AW-1:0]     head;
  logic [LW-1:0]     k;
  logic              cmp_en;
  logic              mism;
  pat_entry_t        pat_rd;
  logic [BYTE_W-1:0] win_rd;
  logic              op_q;
  logic              last_q;

  logic [POS_W-1:0]  pos;
  logic [HITS_W-1:0] hits;
  logic              first_seen;
  logic [POS_W-1:0]  first_start;

  logic [LW-1:0]     eff_len;
  logic [LW-1:0]     len_m1;
  logic [HITS_W-1:0] eff_max;
  logic [AW-1:0]     rd_addr;
  logic              hit;
  logic              done;
  logic [POS_W-1:0]  start;
  logic [HITS_W-1:0] hits_next;
  logic              seen_next;
  logic [POS_W-1:0]  fstart_next;

  always_comb begin
    if (pattern_len == '0) begin
      eff_len = LW'(1);
    end else if (32'(pattern_len) > 32'(PATTERN_MAX)) begin
      eff_len = LW'(PATTERN_MAX);
    end else begin
      eff_len = LW'(pattern_len);
    end
    len_m1  = eff_len - LW'(1);
    eff_max = (hit_limit == '0) ? HITS_W'(1) : hit_limit;
    rd_addr = head - AW'(len_m1) + AW'(k);
  end

  always_comb begin
    done        = (op_q == OP_SCAN) && last_q;
    start       = pos - POS_W'(len_m1);
    hit         = (op_q == OP_SCAN) && (hits < eff_max) && (pos >= POS_W'(len_m1)) && !mism;
    hits_next   = hit ? hits + HITS_W'(1) : hits;
    seen_next   = first_seen || hit;
    fstart_next = (hit && !first_seen) ? start : first_start;
  end

  assign status.k_last   = (k == len_m1);
  assign status.out_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= PATTERN_LEN_RESET;
      hit_limit   <= HIT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LEN: pattern_len <= cfg_data[PLEN_W-1:0];
        REG_HIT_LIMIT:   hit_limit   <= cfg_data[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  // pattern and window memories
  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.op == OP_WRITE
        && 32'(in_item.pattern_index) < 32'(PATTERN_MAX)) begin
      pat_mem[AW'(in_item.pattern_index)] <= '{care: in_item.care, value: in_item.pattern_byte};
    end
    if (cmd.accept && in_item.op == OP_SCAN) begin
      win_mem[head + AW'(1)] <= in_item.data_byte;
    end
    if (cmd.issue) begin
      pat_rd <= pat_mem[AW'(k)];
      win_rd <= win_mem[rd_addr];
    end
    if (cmd.accept) begin
      op_q   <= in_item.op;
      last_q <= in_item.last_byte;
    end
  end

  // compare loop
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      k      <= '0;
      cmp_en <= 1'b0;
      mism   <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
      if (cmd.accept) begin
        k    <= '0;
        mism <= 1'b0;
        if (in_item.op == OP_SCAN) begin
          head <= head + AW'(1);
        end
      end else begin
        if (cmd.issue) begin
          k <= k + LW'(1);
        end
        if (cmp_en && pat_rd.care && win_rd != pat_rd.value) begin
          mism <= 1'b1;
        end
      end
    end
  end

  // section counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      hits        <= '0;
      first_seen  <= 1'b0;
      first_start <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
        if (op_q == OP_SCAN) begin
          if (done) begin
            pos         <= '0;
            hits        <= '0;
            first_seen  <= 1'b0;
            first_start <= '0;
          end else begin
            pos         <= pos + POS_W'(1);
            hits        <= hits_next;
            first_seen  <= seen_next;
            first_start <= fstart_next;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item.match_here   <= hit;
      out_item.match_start  <= hit ? start : '0;
      out_item.hit_count    <= hits_next;
      out_item.first_found  <= seen_next;
      out_item.first_offset <= seen_next ? fstart_next : '0;
      out_item.section_done <= done;
    end
  end

  `MBPS_ASSERT_IMP(a_match_counted, out_valid && out_item.match_here, out_item.hit_count != '0)
  `MBPS_ASSERT_IMP(a_match_first, out_valid && out_item.match_here, out_item.first_found)
  `MBPS_ASSERT_NXT(a_section_cleared, cmd.load && done, hits == '0 && !first_seen && pos == '0)

endmodule

// File: design/masked_byte_pattern_scanner_unit.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_item (in_item_t)
// out      output     out_valid / out_ready  out_item (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A pattern write goes IDLE, EMIT; a scanned byte goes IDLE, SCAN,
// DRAIN, EMIT. In SCAN the compare loop reads one pattern entry and one window byte
// per cycle from both memories for L entries, L being pattern_len held to 1..PATTERN_MAX.
// Reset is synchronous on rst; no clearing pass. cfg_ready is always high.
// The result register frees the input side: a new item is taken while a
// result waits; a stalled output holds the following item in its EMIT state.
module masked_byte_pattern_scanner_unit
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  mbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  mbps_datapath #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: test/scan_result_checker.sv
`timescale 1ns / 100ps

module scan_result_checker
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    results_due
);

  logic [BYTE_W-1:0] sig_byte [PATTERN_MAX];
  logic              sig_care [PATTERN_MAX];
  logic [BYTE_W-1:0] history  [PATTERN_MAX];
  logic [POS_W-1:0]  offset;
  logic [HITS_W-1:0] hits;
  logic              seen;
  logic [POS_W-1:0]  first_at;
  logic [PLEN_W-1:0] len_reg;
  logic [HITS_W-1:0] limit_reg;
  out_item_t         scan_results_due [$];
  int                fail_tally = 0;

  function automatic out_item_t advance_scanner(in_item_t it);
    out_item_t         r;
    int unsigned       span;
    logic [HITS_W-1:0] ceiling;
    bit                hit;
    r = '0;
    if (it.op == OP_WRITE) begin
      if (int'(it.pattern_index) < PATTERN_MAX) begin
        sig_byte[it.pattern_index] = it.pattern_byte;
        sig_care[it.pattern_index] = it.care;
      end
    end else begin
      span = (len_reg == '0) ? 1 :
             ((int'(len_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg));
      ceiling = (limit_reg == '0) ? HITS_W'(1) : limit_reg;
      for (int j = PATTERN_MAX - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = it.data_byte;
      hit = (hits < ceiling) && (offset >= POS_W'(span - 1));
      for (int k = 0; k < span; k++) begin
        if (sig_care[k] && history[span-1-k] != sig_byte[k]) hit = 0;
      end
      if (hit) begin
        r.match_here  = 1'b1;
        r.match_start = offset - POS_W'(span - 1);
        hits          = hits + HITS_W'(1);
        if (!seen) begin
          seen     = 1'b1;
          first_at = r.match_start;
        end
      end
      offset = offset + POS_W'(1);
      r.section_done = it.last_byte;
    end
    r.hit_count    = hits;
    r.first_found  = seen;
    r.first_offset = seen ? first_at : '0;
    if (r.section_done) begin
      offset   = '0;
      hits     = '0;
      seen     = 1'b0;
      first_at = '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        sig_byte[j] = '0;
        sig_care[j] = 1'b0;
        history[j]  = '0;
      end
      offset    = '0;
      hits      = '0;
      seen      = 1'b0;
      first_at  = '0;
      len_reg   = PATTERN_LEN_RESET;
      limit_reg = HIT_LIMIT_RESET;
      scan_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LEN: len_reg   = cfg_data[PLEN_W-1:0];
          REG_HIT_LIMIT:   limit_reg = cfg_data[HITS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) scan_results_due.push_back(advance_scanner(in_item));
      if (out_valid && out_ready) begin
        if (scan_results_due.size() == 0) begin
          $error("result item with none expected");
          fail_tally++;
        end else begin
          want = scan_results_due.pop_front();
          check_field("match_here", POS_W'(want.match_here), POS_W'(out_item.match_here));
          check_field("match_start", want.match_start, out_item.match_start);
          check_field("hit_count", POS_W'(want.hit_count), POS_W'(out_item.hit_count));
          check_field("first_found", POS_W'(want.first_found), POS_W'(out_item.first_found));
          check_field("first_offset", want.first_offset, out_item.first_offset);
          check_field("section_done", POS_W'(want.section_done),
                      POS_W'(out_item.section_done));
        end
      end
    end
    results_due <= scan_results_due.size();
    failures    <= fail_tally;
  end

endmodule

// File: test/tb_masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner_unit;
  import mbps_pkg::*;

  localparam int PATTERN_MAX = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL   = 480;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_LEN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                    mismatches;
  int                    results_due;
  int unsigned           cycles = 0;
  int unsigned           sent   = 0;
  bit                    hold_output = 1'b0;
  bit                    steady      = 1'b0;
  logic [BYTE_W-1:0]     sig_byte [PATTERN_MAX];
  bit                    sig_care [PATTERN_MAX];
  int unsigned           span = 1;

  masked_byte_pattern_scanner_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scan_result_checker #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(mismatches), .results_due(results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("masked_byte_pattern_scanner_unit test failed");
      $finish;
    end
  end

  // result side: random stall per item, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic load_entry(int unsigned idx, logic [BYTE_W-1:0] b, bit c);
    in_item_t it;
    it.op            = OP_WRITE;
    it.pattern_index = IDX_W'(idx);
    it.pattern_byte  = b;
    it.care          = c;
    it.data_byte     = BYTE_W'($urandom);
    it.last_byte     = 1'($urandom_range(0, 1));
    sig_byte[idx]    = b;
    sig_care[idx]    = c;
    send_item(it);
  endtask

  task automatic scan_byte(logic [BYTE_W-1:0] b, bit closing);
    in_item_t it;
    it.op            = OP_SCAN;
    it.pattern_index = IDX_W'($urandom);
    it.pattern_byte  = BYTE_W'($urandom);
    it.care          = 1'($urandom_range(0, 1));
    it.data_byte     = b;
    it.last_byte     = closing;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_config(logic [PLEN_W-1:0] len, logic [HITS_W-1:0] lim);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[PLEN_W-1:0] = len;
    cfg_valid <= 1'b1;
    cfg_index <= REG_PATTERN_LEN;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    word = CFG_DATA_W'($urandom);
    word[HITS_W-1:0] = lim;
    cfg_index <= REG_HIT_LIMIT;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span = (len == '0) ? 1 : ((int'(len) > PATTERN_MAX) ? PATTERN_MAX : int'(len));
  endtask

  task automatic scan_section(bit closing);
    logic [BYTE_W-1:0] bytes [$];
    int unsigned       goal;
    int unsigned       pick;
    int unsigned       spot;
    goal = $urandom_range(1, span + 8);
    while (bytes.size() < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        for (int k = 0; k < span; k++)
          bytes.push_back(sig_care[k] ? sig_byte[k] : BYTE_W'($urandom));
      end else if (pick < 7) begin
        bytes.push_back(BYTE_W'($urandom));
      end else begin
        // near miss: one byte disturbed, if the spot picked is a compared one
        spot = $urandom_range(0, span - 1);
        for (int k = 0; k < span; k++)
          bytes.push_back((sig_care[k] && k != spot) ? sig_byte[k] :
                          (sig_care[k] ? ~sig_byte[k] : BYTE_W'($urandom)));
      end
    end
    foreach (bytes[i]) begin
      if ($urandom_range(0, 29) == 0)
        load_entry($urandom_range(0, span - 1), BYTE_W'($urandom),
                   ($urandom_range(0, 3) != 0));
      scan_byte(bytes[i], closing && (i == bytes.size() - 1));
    end
  endtask

  initial begin
    int unsigned       phase;
    logic [PLEN_W-1:0] len;
    logic [HITS_W-1:0] lim;
    int unsigned       sections;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-entry pattern under reset settings, hit on the closing byte
    load_entry(63, 8'hFF, 1'b0);
    load_entry(0, 8'h00, 1'b1);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h00, 1'b1);
    load_entry(0, 8'hFF, 1'b1);
    scan_byte(8'hFF, 1'b1);
    drain();

    // zero length and zero limit, wildcard entry
    set_config(7'd0, 10'd0);
    load_entry(0, 8'h5A, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'h12, 1'b1);
    drain();

    // three entries with a wildcard in the middle; short section; saturation
    set_config(7'd3, 10'd2);
    load_entry(0, 8'h11, 1'b1);
    load_entry(1, 8'h00, 1'b0);
    load_entry(2, 8'h33, 1'b1);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'h22, 1'b1);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'h22, 1'b0);
    scan_byte(8'h33, 1'b0);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h33, 1'b0);
    drain();
    // limit lowered below the running count
    set_config(7'd3, 10'd1);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'h44, 1'b0);
    scan_byte(8'h33, 1'b1);

    phase = 0;
    while (sent < ITEM_GOAL) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:       len = 7'd1;
        1:       len = 7'd0;
        2:       len = 7'd64;
        3:       len = PLEN_W'($urandom_range(65, 127));
        4, 5, 6: len = PLEN_W'($urandom_range(7, 16));
        default: len = PLEN_W'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 11))
        0:       lim = 10'd0;
        1:       lim = 10'd1023;
        2:       lim = 10'd1;
        3:       lim = 10'd1000;
        default: lim = HITS_W'($urandom_range(1, 6));
      endcase
      if (phase == 0) len = 7'd64;
      if (phase == 1) begin
        len = 7'd127;
        lim = 10'd1023;
      end
      set_config(len, lim);
      for (int k = 0; k < span; k++)
        load_entry(k, BYTE_W'($urandom), ($urandom_range(0, 3) != 0));
      if (phase == 0) hold_output = 1'b1;
      sections = $urandom_range(1, 4);
      for (int s = 0; s < sections && sent < ITEM_GOAL; s++)
        scan_section((s != sections - 1) || ($urandom_range(0, 4) != 0));
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("masked_byte_pattern_scanner_unit test passed");
    end else begin
      $display("masked_byte_pattern_scanner_unit test failed");
    end
    $finish;
  end

endmodule
